@@ src/ialu_pkg.sv @@
// Shared types and constants for the integer ALU with flags.
package ialu_pkg;

  typedef enum logic [2:0] {
    OP_ADDI = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUBI = 3'd2,
    OP_SUB  = 3'd3,
    OP_MULS = 3'd4,
    OP_MULU = 3'd5,
    OP_DIVS = 3'd6,
    OP_DIVU = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  localparam int PORT_W = 32;

  // One classified operation as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]        op;
    logic [PORT_W-1:0] a;
    logic [PORT_W-1:0] b;
    logic [PORT_W-1:0] c;
  } op_word_t;

endpackage

@@ src/ialu_front.sv @@
// Front end: accepts input words and holds them in a two-entry queue.
module ialu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ialu_pkg::op_word_t in_word,
  output logic              q_valid,
  input  logic              q_ready,
  output ialu_pkg::op_word_t q_word
);
  import ialu_pkg::*;

  op_word_t   slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = slot_r[rd_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= in_word;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count did not grow on push");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> (rd_r == wr_r))
    else $error("empty queue with split pointers");

endmodule

@@ src/ialu_back.sv @@
// Back end: executes one operation at a time and keeps the flag register.
module ialu_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  ialu_pkg::op_word_t q_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_result_low,
  output logic [31:0]        out_result_high,
  output logic               out_writes_high,
  output logic               out_zero_flag,
  output logic               out_sign_flag,
  output logic               out_carry_flag,
  output logic               out_divide_error
);
  import ialu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  state_t          st_r, st_nxt;
  logic [2:0]      op_r;
  logic [W-1:0]    a_r, b_r;
  logic            neg_r;
  logic [W-1:0]    quo_r, rem_r;
  logic [CW-1:0]   cnt_r;
  logic [2:0]      flag_r;
  logic [31:0]     lo_r, hi_r;
  logic            wh_r, de_r;
  logic            take, fin;

  // Operand views of the queue word.
  logic [W-1:0]    qa, qb, qc, nb, s1, s2, abs_a, abs_b, addend;
  logic            c1, c2, sa, sb, qneg;
  logic [W:0]      sum1, sum2;
  logic [W:0]      trial;
  logic [2*W-1:0]  prod_u, prod_s;
  logic [W:0]      corr;
  logic [W-1:0]    q_fin, q_neg;

  assign take    = (st_r == ST_IDLE) && q_valid;
  assign q_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_DONE);
  assign fin     = out_valid && out_ready;

  assign qa = q_word.a[W-1:0];
  assign qb = q_word.b[W-1:0];
  assign qc = q_word.c[W-1:0];
  assign nb = (~qb) + {{(W-1){1'b0}}, 1'b1};
  assign sa = qa[W-1];
  assign sb = qb[W-1];
  assign abs_a = sa && (q_word.op == OP_DIVS) ? (~qa) + 1'b1 : qa;
  assign abs_b = sb && (q_word.op == OP_DIVS) ? (~qb) + 1'b1 : qb;
  assign qneg  = (sa ^ sb) && (q_word.op == OP_DIVS);
  assign addend = q_word.op[1] ? nb : qb;
  assign sum1 = {1'b0, qa} + {1'b0, addend};
  assign c1   = sum1[W];
  assign s1   = sum1[W-1:0];
  assign sum2 = {1'b0, s1} + {1'b0, qc};
  assign c2   = q_word.op[0] & sum2[W];
  assign s2   = q_word.op[0] ? sum2[W-1:0] : s1;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, a_r[W-1]} - {1'b0, b_r};
  assign q_fin = {quo_r[W-2:0], ~trial[W]};
  assign q_neg = (~q_fin) + {{(W-1){1'b0}}, 1'b1};

  // One unsigned W x W multiplier registered in ST_MUL. The signed product
  // subtracts each operand from the high half where the other one is negative.
  always_comb begin
    prod_u = {{W{1'b0}}, a_r} * {{W{1'b0}}, b_r};
    corr   = {1'b0, {W{a_r[W-1]}} & b_r} + {1'b0, {W{b_r[W-1]}} & a_r};
    if (op_r == OP_MULS) begin
      prod_s = prod_u - {corr[W-1:0], {W{1'b0}}};
    end else begin
      prod_s = prod_u;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_word.op inside {OP_MULS, OP_MULU}) st_nxt = ST_MUL;
          else if (q_word.op inside {OP_DIVS, OP_DIVU} && qb != '0) st_nxt = ST_DIV;
          else st_nxt = ST_DONE;
        end
      end
      ST_MUL:  st_nxt = ST_DONE;
      ST_DIV:  if (cnt_r == CW'(1)) st_nxt = ST_DONE;
      ST_DONE: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      flag_r <= 3'b000;
    end else begin
      st_r <= st_nxt;
      if (take) begin
        if (!q_word.op[2]) begin
          flag_r[2] <= c1 | c2;
          flag_r[0] <= (s2 == '0);
          flag_r[1] <= (s2 != '0) && s2[W-1];
        end else if (q_word.op == OP_DIVS && qb == '0) begin
          flag_r[1:0] <= 2'b00;
        end
      end else if (st_r == ST_MUL) begin
        flag_r[0] <= (prod_s == '0);
        if (op_r == OP_MULS) flag_r[1] <= (prod_s != '0) && prod_s[2*W-1];
      end else if (st_r == ST_DIV && cnt_r == CW'(1)) begin
        flag_r[0] <= (q_fin == '0);
        if (op_r == OP_DIVS) begin
          flag_r[1] <= neg_r && (q_fin != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r  <= q_word.op;
      a_r   <= (q_word.op == OP_DIVS || q_word.op == OP_DIVU) ? abs_a : qa;
      b_r   <= (q_word.op == OP_DIVS || q_word.op == OP_DIVU) ? abs_b : qb;
      neg_r <= qneg;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= CW'(W);
      lo_r  <= '0;
      hi_r  <= '0;
      wh_r  <= 1'b0;
      de_r  <= 1'b0;
      if (!q_word.op[2]) begin
        lo_r <= 32'(s2);
      end else if (q_word.op[1] && qb == '0) begin
        de_r <= 1'b1;
      end
    end else if (st_r == ST_MUL) begin
      lo_r <= 32'(prod_s[W-1:0]);
      hi_r <= 32'(prod_s[2*W-1:W]);
      wh_r <= 1'b1;
    end else if (st_r == ST_DIV) begin
      a_r   <= {a_r[W-2:0], 1'b0};
      rem_r <= trial[W] ? {rem_r[W-2:0], a_r[W-1]} : trial[W-1:0];
      quo_r <= q_fin;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        wh_r <= 1'b1;
        if (neg_r) begin
          lo_r <= 32'(q_neg);
          hi_r <= 32'({W{(q_fin != '0)}});
        end else begin
          lo_r <= 32'(q_fin);
          hi_r <= '0;
        end
      end
    end
  end

  assign out_result_low   = lo_r;
  assign out_result_high  = hi_r;
  assign out_writes_high  = wh_r;
  assign out_zero_flag    = flag_r[0];
  assign out_sign_flag    = flag_r[1];
  assign out_carry_flag   = flag_r[2];
  assign out_divide_error = de_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_divide_error && out_writes_high))
    else $error("divide error with a written result");
  // Add and subtract set at most one of zero and sign.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_writes_high && !out_divide_error |->
      !(out_zero_flag && out_sign_flag))
    else $error("zero and sign both set");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DIV |-> cnt_r != '0)
    else $error("divider ran past its last step");

endmodule

@@ src/integer_alu_with_flags_top.sv @@
// Top level of the integer ALU with zero, sign and carry flags.
// Add and subtract words go from idle straight to ST_DONE; multiplies pass through ST_MUL,
// and nonzero-divisor divides through ST_DIV, one quotient bit per cycle.
// The back end runs one word at a time; the two-entry input queue keeps accepting
// while it has room; the back end takes a new word only after its last result is taken.
// Synchronous active-low reset empties the queue, idles the back end and clears all flags.
module integer_alu_with_flags_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [31:0] in_extra_addend,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_low,
  output logic [31:0] out_result_high,
  output logic        out_writes_high,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_carry_flag,
  output logic        out_divide_error
);
  import ialu_pkg::*;

  op_word_t in_word, q_word;
  logic     q_valid, q_ready;

  // The front end only buffers; all decoding of the opcode happens in the back end.
  assign in_word = '{op: in_opcode, a: in_operand_a, b: in_operand_b, c: in_extra_addend};

  ialu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .q_valid, .q_ready, .q_word
  );

  ialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_word,
    .out_valid, .out_ready, .out_result_low, .out_result_high,
    .out_writes_high, .out_zero_flag, .out_sign_flag, .out_carry_flag,
    .out_divide_error
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the integer ALU with zero, sign and carry flags.
module tb_top;
  import ialu_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM    = 1680;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic [31:0] in_extra_addend;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result_low;
  logic [31:0] out_result_high;
  logic        out_writes_high;
  logic        out_zero_flag;
  logic        out_sign_flag;
  logic        out_carry_flag;
  logic        out_divide_error;

  // One result word as the block presents it.
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        wh;
    logic        z;
    logic        s;
    logic        c;
    logic        derr;
  } alu_result_t;

  // The scoreboard keeps its own copy of the flag register and a queue of the
  // results that the accepted words must produce, in order.
  class alu_scoreboard;
    logic [2:0]  flags;   // bit 0 zero, bit 1 sign, bit 2 carry
    alu_result_t pending[$];
    int          errors;
    int          checked;

    function void clear_state();
      flags   = 3'b000;
      errors  = 0;
      checked = 0;
      pending.delete();
    endfunction

    // Computes what one accepted word gives and queues it.
    function void note_word(opcode_t op, logic [31:0] a, logic [31:0] b, logic [31:0] x);
      alu_result_t r;
      logic [32:0] sum;
      logic [31:0] nb;
      logic [31:0] acc;
      logic        cy;
      logic signed [63:0] sp;
      logic [63:0] up;
      r  = '0;
      nb = -b;
      case (op)
        OP_ADDI, OP_ADD, OP_SUBI, OP_SUB: begin
          cy  = 1'b0;
          sum = {1'b0, a} + {1'b0, ((op == OP_ADDI || op == OP_ADD) ? b : nb)};
          cy  = sum[32];
          acc = sum[31:0];
          if (op == OP_ADD || op == OP_SUB) begin
            sum = {1'b0, acc} + {1'b0, x};
            cy  = cy | sum[32];
            acc = sum[31:0];
          end
          flags = {cy, 2'b00};
          if (acc == 0) flags[0] = 1'b1;
          else if (acc[31]) flags[1] = 1'b1;
          r.lo = acc;
        end
        OP_MULS: begin
          sp = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          flags[1:0] = 2'b00;
          if (sp == 0) flags[0] = 1'b1;
          else if (sp < 0) flags[1] = 1'b1;
          {r.hi, r.lo} = sp;
          r.wh = 1'b1;
        end
        OP_MULU: begin
          up = {32'd0, a} * {32'd0, b};
          flags[0] = (up == 0);
          {r.hi, r.lo} = up;
          r.wh = 1'b1;
        end
        OP_DIVS: begin
          flags[1:0] = 2'b00;
          if (b == 0) begin
            r.derr = 1'b1;
          end else begin
            // Sign-extended 64-bit division makes the overflow case exact.
            sp = $signed({{32{a[31]}}, a}) / $signed({{32{b[31]}}, b});
            if (sp == 0) flags[0] = 1'b1;
            else if (sp < 0) flags[1] = 1'b1;
            {r.hi, r.lo} = sp;
            r.wh = 1'b1;
          end
        end
        default: begin
          if (b == 0) begin
            r.derr = 1'b1;
          end else begin
            r.lo = a / b;
            flags[0] = (r.lo == 0);
            r.wh = 1'b1;
          end
        end
      endcase
      r.z = flags[0];
      r.s = flags[1];
      r.c = flags[2];
      pending.push_back(r);
    endfunction

    function void check_word(alu_result_t got);
      alu_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result word with no expectation: %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.lo !== want.lo) begin
        $display("%0t: result_low expected %h actual %h", $time, want.lo, got.lo);
        errors++;
      end
      if (got.hi !== want.hi) begin
        $display("%0t: result_high expected %h actual %h", $time, want.hi, got.hi);
        errors++;
      end
      if (got.wh !== want.wh) begin
        $display("%0t: writes_high expected %b actual %b", $time, want.wh, got.wh);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: zero_flag expected %b actual %b", $time, want.z, got.z);
        errors++;
      end
      if (got.s !== want.s) begin
        $display("%0t: sign_flag expected %b actual %b", $time, want.s, got.s);
        errors++;
      end
      if (got.c !== want.c) begin
        $display("%0t: carry_flag expected %b actual %b", $time, want.c, got.c);
        errors++;
      end
      if (got.derr !== want.derr) begin
        $display("%0t: divide_error expected %b actual %b", $time, want.derr, got.derr);
        errors++;
      end
    endfunction
  endclass

  alu_scoreboard board;
  int  op_count[8];
  int  words_sent;
  int  quiet_cycles;
  bit  busy_window;   // when set, neither side idles
  bit  timed_out;

  integer_alu_with_flags_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_extra_addend  (in_extra_addend),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_low   (out_result_low),
    .out_result_high  (out_result_high),
    .out_writes_high  (out_writes_high),
    .out_zero_flag    (out_zero_flag),
    .out_sign_flag    (out_sign_flag),
    .out_carry_flag   (out_carry_flag),
    .out_divide_error (out_divide_error)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Roughly one cycle in three idles unless the busy window is open.
  function automatic bit take_break();
    return !busy_window && ($urandom_range(99) < 34);
  endfunction

  // Sends one word: optional idle cycles first, then valid held until accepted.
  // Valid drops only while idling, so back-to-back words keep it high.
  task automatic send_word(opcode_t op, logic [31:0] a, logic [31:0] b, logic [31:0] x);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_operand_a    <= a;
    in_operand_b    <= b;
    in_extra_addend <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(op, a, b, x);
    op_count[op]++;
    words_sent++;
  endtask

  // Operands biased toward the values that stress carries and signs.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(16);
      5:       return -$urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  // Result side: ready idles at random, results are checked as they are taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
      if (out_valid && out_ready)
        board.check_word({out_result_low, out_result_high, out_writes_high,
                          out_zero_flag, out_sign_flag, out_carry_flag,
                          out_divide_error});
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("integer_alu_with_flags_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    opcode_t op;
    int      wait_cycles;
    board = new();
    board.clear_state();
    words_sent  = 0;
    busy_window = 1'b0;
    timed_out   = 1'b0;
    quiet_cycles = 0;
    in_valid        = 1'b0;
    in_opcode       = OP_ADDI;
    in_operand_a    = '0;
    in_operand_b    = '0;
    in_extra_addend = '0;
    out_ready       = 1'b0;
    rst_n           = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: carries, zero and sign results, both multiplies at the
    // extremes, the signed divide overflow, truncation and zero divisors.
    send_word(OP_ADDI, 32'hFFFF_FFFF, 32'h1, 32'h0);
    send_word(OP_ADDI, 32'h7FFF_FFFF, 32'h1, 32'h0);
    send_word(OP_ADD,  32'hFFFF_FFFF, 32'h0, 32'h1);
    send_word(OP_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_SUBI, 32'h5, 32'h0, 32'hFFFF_FFFF);
    send_word(OP_SUBI, 32'h5, 32'h5, 32'h0);
    send_word(OP_SUBI, 32'h0, 32'h1, 32'h0);
    send_word(OP_SUB,  32'h3, 32'h7, 32'h4);
    send_word(OP_SUB,  32'h0, 32'h0, 32'h0);
    send_word(OP_MULS, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send_word(OP_MULS, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_MULS, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_MULU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_MULU, 32'h0, 32'h1234_5678, 32'h0);
    send_word(OP_DIVS, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_DIVS, 32'hFFFF_FFF9, 32'h2, 32'h0);
    send_word(OP_DIVS, 32'h1, 32'h2, 32'h0);
    send_word(OP_DIVS, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_word(OP_ADDI, 32'hFFFF_FFFF, 32'h1, 32'h0);
    send_word(OP_DIVU, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(OP_DIVU, 32'hFFFF_FFFF, 32'h3, 32'h0);
    send_word(OP_DIVU, 32'h2, 32'hFFFF_FFFF, 32'h0);

    // Random words; a stretch in the middle runs with no idling on either side.
    for (int i = 0; i < N_RANDOM; i++) begin
      busy_window = (i >= 600 && i < 900);
      op = opcode_t'($urandom_range(7));
      send_word(op, pick_operand(), pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
    busy_window = 1'b0;

    // Drain, then leave a divide's worth of cycles for any stray result.
    wait_cycles = 0;
    while (board.pending.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (board.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.pending.size());
      board.errors++;
    end

    $display("Sent %0d words, checked %0d results; per opcode: %0d %0d %0d %0d %0d %0d %0d %0d",
             words_sent, board.checked, op_count[0], op_count[1], op_count[2],
             op_count[3], op_count[4], op_count[5], op_count[6], op_count[7]);
    if (board.errors == 0) begin
      $display("integer_alu_with_flags_top regression: pass");
    end else begin
      $display("integer_alu_with_flags_top regression: fail");
    end
    $finish;
  end

endmodule
